/* rtl/point_light_falloff_shader_unit_macros.svh */
// ----------------------------------------------------------------------------
// point light falloff shader unit: assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_FALLOFF_SHADER_UNIT_MACROS_SVH
`define POINT_LIGHT_FALLOFF_SHADER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plfs assertion failed");

// next-cycle implication, disabled during reset
`define PLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plfs assertion failed");

`endif

/* rtl/plfs_pkg.sv */
// ----------------------------------------------------------------------------
// plfs_pkg
// types and constants shared by the point light falloff shader unit
// ----------------------------------------------------------------------------
package plfs_pkg;

  localparam int unsigned MaxLights = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned SlotW     = $clog2(MaxLights);
  localparam int unsigned CountW    = SlotW + 1;
  localparam int unsigned D2W       = 2 * CoordBits + 1;
  localparam int unsigned R2W       = 32;

  localparam logic [15:0] OneQ88 = 16'd256;

  // configuration register indexes
  localparam logic [1:0] RegSpotRadius = 2'd0;
  localparam logic [1:0] RegSpotGain   = 2'd1;
  localparam logic [1:0] RegLightsUsed = 2'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  light_slot;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [23:0] pixel_color;
    logic [15:0] dark_divisor;
  } in_word_t;

  typedef struct packed {
    logic [16:0] light_factor;
    logic [23:0] lit_color;
    logic [15:0] shaded_divisor;
  } out_word_t;

  // classified word held in the queue between front and back
  typedef struct packed {
    op_e         op;
    logic [5:0]  slot;
    logic [15:0] px;
    logic [15:0] py;
    logic [23:0] color;
    logic [15:0] div;
  } q_entry_t;

  typedef struct packed {
    logic [15:0]       radius;
    logic [11:0]       gain;
    logic [CountW-1:0] count;
  } cfg_t;

endpackage

/* rtl/plfs_front.sv */
// ----------------------------------------------------------------------------
// plfs_front
// accepts input words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module plfs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plfs_pkg::in_word_t  in_word_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output plfs_pkg::q_entry_t  q_entry_o
);

  plfs_pkg::q_entry_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;
  plfs_pkg::q_entry_t ent;

  // classify the incoming word
  always_comb begin
    ent.op    = in_word_i.cmd ? plfs_pkg::OP_QUERY : plfs_pkg::OP_LOAD;
    ent.slot  = in_word_i.light_slot;
    ent.px    = in_word_i.point_x;
    ent.py    = in_word_i.point_y;
    ent.color = in_word_i.pixel_color;
    ent.div   = in_word_i.dark_divisor;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* rtl/plfs_back.sv */
// ----------------------------------------------------------------------------
// plfs_back
// light table, nearest-light scan, falloff division and colour scaling
// ----------------------------------------------------------------------------
module plfs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plfs_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  plfs_pkg::q_entry_t  q_entry_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plfs_pkg::out_word_t out_word_o
);

  localparam int unsigned SlotW  = plfs_pkg::SlotW;
  localparam int unsigned CountW = plfs_pkg::CountW;
  localparam int unsigned D2W    = plfs_pkg::D2W;
  localparam int unsigned R2W    = plfs_pkg::R2W;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSqr  = 3'd3;
  localparam logic [2:0] StGain = 3'd4;
  localparam logic [2:0] StChan = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]          state_q;
  logic [31:0]         tbl_mem [plfs_pkg::MaxLights];
  logic [31:0]         rdata_q;
  logic                tbl_we;
  logic [CountW-1:0]   idx_q, n_lim;
  logic                issue, v1_q, v2_q, v3_q;
  logic [15:0]         dx_q, dy_q;
  logic [31:0]         sqx_q, sqy_q;
  logic [D2W-1:0]      d2, min_q;
  logic [R2W-1:0]      r2_q;
  logic [15:0]         px_q, py_q, div_q;
  logic [23:0]         color_q;
  logic [R2W:0]        rem_q, rem_sub;
  logic [16:0]         quo_q, f_q;
  logic [4:0]          dcnt_q;
  logic [33:0]         qsq;
  logic [28:0]         mult_q;
  logic [32:0]         pull_prod;
  logic [15:0]         pull_q;
  logic [15:0]         x_now, y_now, shaded;
  logic [36:0]         pr, pg, pb;
  plfs_pkg::out_word_t res_q, out_q;
  logic                out_valid_q;
  logic                out_free;

  // clamp the light count to the table depth
  assign n_lim = (cfg_i.count > CountW'(plfs_pkg::MaxLights))
               ? CountW'(plfs_pkg::MaxLights) : cfg_i.count;

  assign issue   = (state_q == StScan) && (idx_q < n_lim);
  assign q_pop_o = (state_q == StIdle) && q_valid_i;
  assign tbl_we  = q_pop_o && (q_entry_i.op == plfs_pkg::OP_LOAD);

  // light table: y in the high half, x in the low half
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[q_entry_i.slot] <= {q_entry_i.py, q_entry_i.px};
    end
    rdata_q <= tbl_mem[idx_q[SlotW-1:0]];
  end

  // scan datapath
  assign x_now   = rdata_q[15:0];
  assign y_now   = rdata_q[31:16];
  assign d2      = D2W'(sqx_q) + D2W'(sqy_q);
  assign rem_sub = rem_q - {1'b0, r2_q};
  assign qsq     = 34'(quo_q) * 34'(quo_q);
  assign pull_prod = 33'(div_q - plfs_pkg::OneQ88) * 33'(f_q);
  assign shaded  = div_q - pull_q;

  // per-channel brightening
  assign pr = 37'(color_q[23:16]) * 37'(mult_q);
  assign pg = 37'(color_q[15:8])  * 37'(mult_q);
  assign pb = 37'(color_q[7:0])   * 37'(mult_q);

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      dx_q <= (px_q >= x_now) ? px_q - x_now : x_now - px_q;
      dy_q <= (py_q >= y_now) ? py_q - y_now : y_now - py_q;
    end
    if (v2_q) begin
      sqx_q <= 32'(dx_q) * 32'(dx_q);
      sqy_q <= 32'(dy_q) * 32'(dy_q);
    end
    case (state_q)
      StIdle: begin
        px_q    <= q_entry_i.px;
        py_q    <= q_entry_i.py;
        color_q <= q_entry_i.color;
        div_q   <= q_entry_i.div;
        r2_q    <= R2W'(cfg_i.radius) * R2W'(cfg_i.radius);
        min_q   <= '1;
      end
      StScan: begin
        if (v3_q && (d2 < min_q)) min_q <= d2;
        if (!issue && !v1_q && !v2_q && !v3_q) begin
          rem_q  <= {1'b0, r2_q - min_q[R2W-1:0]};
          quo_q  <= '0;
          dcnt_q <= '0;
        end
      end
      StDiv: begin
        // one quotient bit per cycle
        if (rem_q >= {1'b0, r2_q}) begin
          quo_q <= {quo_q[15:0], 1'b1};
          rem_q <= {rem_sub[R2W-1:0], 1'b0};
        end else begin
          quo_q <= {quo_q[15:0], 1'b0};
          rem_q <= {rem_q[R2W-1:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 5'd1;
      end
      StSqr: begin
        f_q <= qsq[32:16];
      end
      StGain: begin
        mult_q <= 29'h100_0000 + 29'(f_q) * 29'(cfg_i.gain);
        pull_q <= ((f_q != '0) && (div_q > plfs_pkg::OneQ88))
                ? pull_prod[31:16] : 16'd0;
      end
      StChan: begin
        res_q.light_factor <= f_q;
        res_q.lit_color[23:16] <= (pr[36:24] > 13'd255) ? 8'hFF : pr[31:24];
        res_q.lit_color[15:8]  <= (pg[36:24] > 13'd255) ? 8'hFF : pg[31:24];
        res_q.lit_color[7:0]   <= (pb[36:24] > 13'd255) ? 8'hFF : pb[31:24];
        // a divisor at or below one passes through untouched
        res_q.shaded_divisor   <= ((div_q > plfs_pkg::OneQ88) && (shaded < plfs_pkg::OneQ88))
                                ? plfs_pkg::OneQ88 : shaded;
      end
      default: ;
    endcase
    if ((state_q == StOut) && out_free) out_q <= res_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (issue) idx_q <= idx_q + 1'b1;
      // result word valid: set on hand-off, cleared when taken
      if ((state_q == StOut) && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (q_pop_o && (q_entry_i.op == plfs_pkg::OP_QUERY)) state_q <= StScan;
        end
        StScan: begin
          if (!issue && !v1_q && !v2_q && !v3_q) begin
            // no light in reach skips the division with a zero quotient
            state_q <= (min_q < D2W'(r2_q)) ? StDiv : StSqr;
          end
        end
        StDiv: begin
          if (dcnt_q == 5'd16) state_q <= StSqr;
        end
        StSqr:  state_q <= StGain;
        StGain: state_q <= StChan;
        StChan: state_q <= StOut;
        StOut: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/point_light_falloff_shader_unit.sv */
// A query with a light in reach goes through the table scan, the falloff divider and the
// squaring, gain and channel steps to its result word (the divider is skipped when no
// light reaches); a load writes the light table and gives no result.
// Queries are taken one at a time; the table scan reads one light per cycle, the falloff
// divider is bit-serial, and loads retire one per cycle while no query is in progress.
// Reset: asynchronous, active low; clears control and restores register defaults.
// The light table is not cleared and must be loaded before queries read it.
// ----------------------------------------------------------------------------
// point_light_falloff_shader_unit
// point light falloff shading with a table of light positions
// ----------------------------------------------------------------------------
module point_light_falloff_shader_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plfs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plfs_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  plfs_pkg::cfg_t     cfg_q;
  logic               q_valid, q_pop;
  plfs_pkg::q_entry_t q_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= 16'd512;
      cfg_q.gain   <= 12'd256;
      cfg_q.count  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plfs_pkg::RegSpotRadius: cfg_q.radius <= cfg_wdata_i;
        plfs_pkg::RegSpotGain:   cfg_q.gain   <= cfg_wdata_i[11:0];
        plfs_pkg::RegLightsUsed: cfg_q.count  <= cfg_wdata_i[plfs_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  plfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_entry_o  (q_entry)
  );

  plfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_entry_i   (q_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/plfs_checker.sv */
// ----------------------------------------------------------------------------
// plfs_checker
// port-level checks on the point light falloff shader unit
// ----------------------------------------------------------------------------
`include "point_light_falloff_shader_unit_macros.svh"

module plfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input plfs_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input plfs_pkg::out_word_t out_word_o
);

  // a waiting input word holds
  `PLFS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_word_i))
  // a stalled result word holds
  `PLFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o))
  // factor never exceeds one
  `PLFS_ASSERT_NOW(a_factor_range, clk_i, rst_ni, out_valid_o, out_word_o.light_factor <= 17'd65536)
  // full factor pulls the divisor all the way to one
  `PLFS_ASSERT_NOW(a_full_pull, clk_i, rst_ni, out_valid_o && out_word_o.light_factor == 17'd65536, out_word_o.shaded_divisor <= 16'd256)

endmodule

bind point_light_falloff_shader_unit plfs_checker u_plfs_checker (.*);
